// File: sv/kips_pkg.sv
// Package with the shared types and constants of the key/index pair sorter.
`timescale 1ns / 1ps
package kips_pkg;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned POS_W = 10;
    localparam int unsigned ENTRY_W = KEY_W + POS_W;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    // Sequencer states: idle serving beats, then the insertion sort steps.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_I,
        ST_GET_I,
        ST_CMP,
        ST_PUT
    } t_state;

endpackage

// File: sv/kips_if.sv
// Handshake interfaces for the request and result channels.
`timescale 1ns / 1ps
interface kips_req_if;
    logic                      valid;
    logic                      ready;
    logic                      req_type;
    logic [kips_pkg::KEY_W-1:0] key_value;
    logic                      last_key;

    modport source (output valid, req_type, key_value, last_key, input ready);
    modport sink   (input valid, req_type, key_value, last_key, output ready);
endinterface

interface kips_res_if;
    logic                      valid;
    logic                      ready;
    logic                      out_valid;
    logic [kips_pkg::KEY_W-1:0] sorted_key;
    logic [kips_pkg::POS_W-1:0] original_position;
    logic                      final_pair;
    logic                      overflow_seen;

    modport source (output valid, out_valid, sorted_key, original_position, final_pair,
                    overflow_seen, input ready);
    modport sink   (input valid, out_valid, sorted_key, original_position, final_pair,
                    overflow_seen, output ready);
endinterface

// File: sv/kips_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
module kips_ram #(
    parameter int unsigned WIDTH = 42,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read each cycle.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: sv/key_index_pair_sorter_unit.sv
// Key/index pair sorter: collects keys, sorts them stably and replays the pairs.
// Usage: the request channel carries loads (req_type 0) and reads (req_type 1).
// A load appends its key, tagged with its arrival position, to a single RAM
// that holds key and position side by side. The load with last_key set closes
// the set and starts a stable insertion sort that runs in place in that RAM.
// The sort steps through each entry: a read, a fetch, one compare per shift
// plus at most one closing compare, and a write back; no request is taken
// meanwhile. A read is issued to the registered RAM read, and its beat then
// sits in the output register until taken; each read gives exactly one
// result beat, loads give none. A read with nothing left, or made before the
// set is sorted, returns out_valid 0 and the current overflow flag.
// A new request is taken only once the output register is empty, so a
// stalled receiver holds the whole block. Reset clears the counts and flags;
// the RAM contents need no clearing, as only written entries are ever read.
`timescale 1ns / 1ps
module key_index_pair_sorter_unit #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kips_req_if.sink   i_req,
    kips_res_if.source o_res
);
    import kips_pkg::*;

    localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_TWO = CW'(2);

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic          r_sorted, n_sorted;
    logic          r_ovf, n_ovf;
    logic          r_pend, n_pend;
    logic          r_pfinal, n_pfinal;
    logic [ENTRY_W-1:0] r_hold, n_hold;

    logic          r_ov, n_ov;
    logic          r_oval, n_oval;
    logic [KEY_W-1:0] r_okey, n_okey;
    logic [POS_W-1:0] r_opos, n_opos;
    logic          r_ofin, n_ofin;
    logic          r_oovf, n_oovf;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

    logic          acc;
    logic [CW-1:0] base;
    logic          key_gt;

    kips_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_req.ready = (r_state == ST_IDLE) && !r_pend && !r_ov;
    assign acc = i_req.valid && i_req.ready;
    assign base = r_sorted ? '0 : r_count;
    assign key_gt = ram_rdata[ENTRY_W-1:POS_W] > r_hold[ENTRY_W-1:POS_W];

    assign o_res.valid = r_ov;
    assign o_res.out_valid = r_oval;
    assign o_res.sorted_key = r_okey;
    assign o_res.original_position = r_opos;
    assign o_res.final_pair = r_ofin;
    assign o_res.overflow_seen = r_oovf;

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc && i_req.req_type == REQ_LOAD && i_req.last_key
                        && n_count >= CNT_TWO) begin
                    n_state = ST_RD_I;
                end
            end
            ST_RD_I:  n_state = ST_GET_I;
            ST_GET_I: n_state = ST_CMP;
            ST_CMP: begin
                if (!key_gt || r_j == CNT_ONE) begin
                    n_state = ST_PUT;
                end
            end
            ST_PUT: begin
                if (r_i + CNT_ONE >= r_count) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_RD_I;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath, RAM control and output register.
    always_comb begin
        n_count = r_count;
        n_rp = r_rp;
        n_i = r_i;
        n_j = r_j;
        n_sorted = r_sorted;
        n_ovf = r_ovf;
        n_pend = 1'b0;
        n_pfinal = r_pfinal;
        n_hold = r_hold;
        n_ov = r_ov && !o_res.ready;
        n_oval = r_oval;
        n_okey = r_okey;
        n_opos = r_opos;
        n_ofin = r_ofin;
        n_oovf = r_oovf;
        ram_we = 1'b0;
        ram_waddr = r_j[AW-1:0];
        ram_wdata = r_hold;
        ram_raddr = r_rp[AW-1:0];

        // Read data of an issued read beat lands in the output register.
        if (r_pend) begin
            n_ov = 1'b1;
            n_oval = 1'b1;
            n_okey = ram_rdata[ENTRY_W-1:POS_W];
            n_opos = ram_rdata[POS_W-1:0];
            n_ofin = r_pfinal;
            n_oovf = r_ovf;
        end

        case (r_state)
            ST_IDLE: begin
                if (acc && i_req.req_type == REQ_LOAD) begin
                    if (r_sorted) begin
                        n_rp = '0;
                        n_ovf = 1'b0;
                        n_sorted = 1'b0;
                    end
                    n_count = base;
                    if (base < CNT_MAX) begin
                        ram_we = 1'b1;
                        ram_waddr = base[AW-1:0];
                        ram_wdata = {i_req.key_value, POS_W'(base)};
                        n_count = base + CNT_ONE;
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_req.last_key) begin
                        n_rp = '0;
                        n_i = CNT_ONE;
                        if (n_count < CNT_TWO) begin
                            n_sorted = 1'b1;
                        end
                    end
                end else if (acc) begin
                    if (r_sorted && r_rp < r_count) begin
                        n_pend = 1'b1;
                        n_pfinal = (r_rp + CNT_ONE == r_count);
                        n_rp = r_rp + CNT_ONE;
                    end else begin
                        n_ov = 1'b1;
                        n_oval = 1'b0;
                        n_okey = '0;
                        n_opos = '0;
                        n_ofin = 1'b0;
                        n_oovf = r_ovf;
                    end
                end
            end
            ST_RD_I: begin
                ram_raddr = r_i[AW-1:0];
            end
            ST_GET_I: begin
                n_hold = ram_rdata;
                n_j = r_i;
                ram_raddr = AW'(r_i - CNT_ONE);
            end
            ST_CMP: begin
                // Shift the larger neighbour up and look one further down.
                if (key_gt) begin
                    ram_we = 1'b1;
                    ram_waddr = r_j[AW-1:0];
                    ram_wdata = ram_rdata;
                    n_j = r_j - CNT_ONE;
                    ram_raddr = AW'(r_j - CNT_TWO);
                end
            end
            ST_PUT: begin
                ram_we = 1'b1;
                ram_waddr = r_j[AW-1:0];
                ram_wdata = r_hold;
                n_i = r_i + CNT_ONE;
                if (r_i + CNT_ONE >= r_count) begin
                    n_sorted = 1'b1;
                end
            end
            default: begin
                n_pend = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rp <= '0;
            r_sorted <= 1'b0;
            r_ovf <= 1'b0;
            r_pend <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rp <= n_rp;
            r_sorted <= n_sorted;
            r_ovf <= n_ovf;
            r_pend <= n_pend;
            r_ov <= n_ov;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_i <= n_i;
        r_j <= n_j;
        r_pfinal <= n_pfinal;
        r_hold <= n_hold;
        r_oval <= n_oval;
        r_okey <= n_okey;
        r_opos <= n_opos;
        r_ofin <= n_ofin;
        r_oovf <= n_oovf;
    end

    // A pending read always produces a result beat in the next cycle.
    a_pend_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |=> r_ov) else $error("read beat lost");

    // Requests are taken only while the sequencer is idle.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_state == ST_IDLE) else $error("ready while sorting");

    // The read pointer never runs past the entry count.
    a_rp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rp <= r_count) else $error("read pointer beyond set");
endmodule
